>>> rtl/mecanum_yaw_pid_mixer_macros.svh
// Assertion macros for the mecanum yaw PID mixer.
// Included by the RTL files that carry concurrent assertions.
`ifndef MECANUM_YAW_PID_MIXER_MACROS_SVH
`define MECANUM_YAW_PID_MIXER_MACROS_SVH
`ifndef SYNTHESIS
`define MYPM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define MYPM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MYPM_ASSERT_IMP(label, clk, rst, ante, cons)
`define MYPM_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/mypm_pkg.sv
// Shared types and constants for the mecanum yaw PID mixer.
// No dependencies.
package mypm_pkg;
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_KP    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KI    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KD    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BIAS  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_CAP   = 3'd6;
   localparam int DIV_W = 16;

   // divider handshake between sequencer and divider
   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;
endpackage

>>> rtl/mecanum_yaw_pid_mixer.sv
// Mecanum yaw PID mixer: sequencer around one shared multiplier.
// The serial divider is used only when the wheel factor needs it. A req word can be
// taken in the same cycle that rsp_tvalid rises unless a config word is pending, but
// no new req word is taken until the last one is through; a rsp word left
// unread stalls the next word in its last step. Reset (synchronous, active high)
// loads register defaults and zeroes state. Depends on mypm_pkg, mypm_divider, macros.
`include "mecanum_yaw_pid_mixer_macros.svh"
module mecanum_yaw_pid_mixer
   import mypm_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // yaw_rate[15:0], forward_stick[26:16], strafe_stick[37:27], turn_stick[48:38]
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // front_left[15:0], front_right[31:16], rear_left[47:32], rear_right[63:48]
   output logic [63:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   localparam int FW = FRAC_BITS + 12;
   localparam int SH = 24 - FRAC_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_M0, S_M1, S_M2, S_ACC, S_CORR, S_FF, S_FS, S_MIX, S_FAC,
      S_DIVW, S_SCALE, S_OUT
   } state_type;

   state_type state_ff;
   logic [23:0] kp_ff, ki_ff, kd_ff;
   logic [10:0] lim_ff, cap_ff;
   logic signed [6:0] bias_ff;
   logic [2:0] gain_ff;
   logic signed [17:0] e_ff, e1_ff, e2_ff;
   logic signed [47:0] acc_ff;
   logic signed [11:0] corr_ff;
   logic signed [FW-1:0] ff_ff, fs_ff;
   logic signed [10:0] fx_ff, sx_ff;
   logic signed [51:0] inc_ff;
   logic signed [13:0] w_ff [4];
   logic [3:0] fac_ff;
   logic [1:0] idx_ff;
   logic rsp_valid_ff;
   logic [63:0] rsp_data_ff;
   logic [63:0] wheel_ff;

   // shared multiplier: signed 27 x signed 27
   logic signed [26:0] ma, mb;
   logic signed [53:0] mp;
   assign mp = ma * mb;

   div_req_type div_req;
   div_rsp_type div_rsp;
   mypm_divider u_div (.clock(clock), .reset(reset), .div_req(div_req),
                       .div_rsp(div_rsp));

   // input decode
   logic signed [15:0] rate;
   logic signed [11:0] dturn;
   logic signed [13:0] tgt;
   logic signed [18:0] err;
   assign rate  = req_tdata[15:0];
   assign dturn = 12'sd1024 - $signed({1'b0, req_tdata[48:38]});
   // trunc(d*4/5) with d in [-1023,1024]: magnitude via reciprocal, exact here
   logic [11:0] dmag;
   logic [24:0] dprod;
   logic [13:0] tmag;
   assign dmag  = dturn[11] ? 12'(-dturn) : 12'(dturn);
   assign dprod = 25'({dmag, 2'b00}) * 25'd6554;
   assign tmag  = 14'(dprod >> 15);
   assign tgt   = dturn[11] ? -$signed(tmag) : $signed(tmag);
   assign err   = 19'(rate) - 19'(tgt) - 19'(bias_ff);

   logic signed [FW+4:0] fnum;
   logic signed [FW+4:0] fq;
   logic signed [47:0] accn;
   logic signed [52:0] acc_sum;
   logic signed [48+FRAC_BITS:0] cnum;
   logic signed [48:0] cv;
   logic signed [13:0] mx, a0, a1, a2, a3;
   logic signed [13:0] ab [4];

   function automatic logic signed [13:0] absv(input logic signed [13:0] v);
      return v[13] ? -v : v;
   endfunction

   // divide by 10 truncating toward zero via reciprocal multiply and fixup
   function automatic logic signed [FW+4:0] div10(input logic signed [FW+4:0] n);
      logic [FW+4:0] m;
      logic [FW+4:0] q;
      logic [FW+4:0] r;
      m = n[FW+4] ? (FW+5)'(-n) : (FW+5)'(n);
      q = (FW+5)'(((2*FW+10)'(m) * (2*FW+10)'(((FW+5)'(1) << (FW+3)) / 5))
                  >> (FW+4));
      r = m - q * (FW+5)'(10);
      if (r >= (FW+5)'(10)) q = q + (FW+5)'(1);
      return n[FW+4] ? -$signed(q) : $signed(q);
   endfunction

   always_comb begin
      ma = '0; mb = '0;
      unique case (state_ff)
         S_M0: begin
            ma = 27'(e_ff);
            mb = 27'(kp_ff) + 27'(ki_ff) + 27'(kd_ff);
         end
         S_M1: begin
            ma = 27'(e1_ff);
            mb = -(27'(kp_ff) + 27'({kd_ff, 1'b0}));
         end
         S_M2: begin ma = 27'(e2_ff); mb = 27'({1'b0, kd_ff}); end
         S_SCALE: begin ma = 27'(w_ff[idx_ff]); mb = 27'({1'b0, fac_ff}); end
         default: begin ma = '0; mb = '0; end
      endcase
   end

   always_comb begin
      acc_sum = 53'(acc_ff) + 53'(inc_ff >>> SH);
      if (acc_sum > 53'sh7FFFFFFFFFFF) accn = 48'sh7FFFFFFFFFFF;
      else if (acc_sum < -53'sh800000000000) accn = 48'sh800000000000;
      else accn = 48'(acc_sum);
      cnum = ((49+FRAC_BITS)'(corr_ff) <<< FRAC_BITS) - (49+FRAC_BITS)'(acc_ff);
      if (cnum[48+FRAC_BITS])
         cv = 49'(-((-cnum) >>> FRAC_BITS));
      else
         cv = 49'(cnum >>> FRAC_BITS);
      fnum = (FW+5)'(ff_ff) * (FW+5)'(7);
      if (state_ff == S_FF)
         fnum = fnum + ((FW+5)'(fx_ff) * (FW+5)'(3) <<< FRAC_BITS);
      else begin
         fnum = (FW+5)'(fs_ff) * (FW+5)'(7) + ((FW+5)'(sx_ff) * (FW+5)'(3) <<< FRAC_BITS);
      end
      fq = div10(fnum);
      for (int i = 0; i < 4; i++) ab[i] = absv(w_ff[i]);
      a0 = (ab[0] > ab[1]) ? ab[0] : ab[1];
      a1 = (ab[2] > ab[3]) ? ab[2] : ab[3];
      mx = (a0 > a1) ? a0 : a1;
      a2 = 14'(ff_ff >>> FRAC_BITS) + 14'(ff_ff[FW-1] && ff_ff[FRAC_BITS-1:0] != '0);
      a3 = 14'(fs_ff >>> FRAC_BITS) + 14'(fs_ff[FW-1] && fs_ff[FRAC_BITS-1:0] != '0);
   end

   assign div_req.start    = (state_ff == S_FAC) && (mx > $signed({3'b0, cap_ff}));
   assign div_req.dividend = 16'(gain_ff) * 16'(cap_ff);
   assign div_req.divisor  = 16'(mx);

   // config only while nothing is in flight; a config word goes first
   assign req_tready = (state_ff == S_IDLE) && !csr_valid;
   assign csr_ready  = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kp_ff <= 24'd335544; ki_ff <= 24'd1678; kd_ff <= 24'd167772;
         lim_ff <= 11'd1000; bias_ff <= 7'sd2; gain_ff <= 3'd3; cap_ff <= 11'd660;
         e_ff <= '0; e1_ff <= '0; e2_ff <= '0; acc_ff <= '0; corr_ff <= '0;
         ff_ff <= '0; fs_ff <= '0; rsp_valid_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_KP:    kp_ff   <= csr_data[23:0];
               REG_KI:    ki_ff   <= csr_data[23:0];
               REG_KD:    kd_ff   <= csr_data[23:0];
               REG_LIMIT: lim_ff  <= csr_data[10:0];
               REG_BIAS:  bias_ff <= csr_data[6:0];
               REG_GAIN:  gain_ff <= csr_data[2:0];
               REG_CAP:   cap_ff  <= csr_data[10:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req_tvalid && req_tready) begin
               e2_ff <= e1_ff; e1_ff <= e_ff; e_ff <= 18'(err);
               fx_ff <= 11'($signed({1'b0, req_tdata[26:16]}) - 12'sd1024);
               sx_ff <= 11'($signed({1'b0, req_tdata[37:27]}) - 12'sd1024);
               state_ff <= S_M0;
            end
            S_M0: begin inc_ff <= 52'(mp); state_ff <= S_M1; end
            S_M1: begin inc_ff <= inc_ff + 52'(mp); state_ff <= S_M2; end
            S_M2: begin inc_ff <= inc_ff + 52'(mp); state_ff <= S_ACC; end
            S_ACC: begin acc_ff <= accn; state_ff <= S_CORR; end
            S_CORR: begin
               if (cv > 49'($signed({1'b0, lim_ff}))) corr_ff <= 12'({1'b0, lim_ff});
               else if (cv < -49'($signed({1'b0, lim_ff})))
                  corr_ff <= -12'({1'b0, lim_ff});
               else corr_ff <= 12'(cv);
               state_ff <= S_FF;
            end
            S_FF: begin ff_ff <= FW'(fq); state_ff <= S_FS; end
            S_FS: begin fs_ff <= FW'(fq); state_ff <= S_MIX; end
            S_MIX: begin
               w_ff[0] <= a2 + a3 - 14'(corr_ff);
               w_ff[1] <= a2 - a3 + 14'(corr_ff);
               w_ff[2] <= a2 - a3 - 14'(corr_ff);
               w_ff[3] <= a2 + a3 + 14'(corr_ff);
               state_ff <= S_FAC;
            end
            S_FAC: begin
               if (div_req.start) state_ff <= S_DIVW;
               else begin fac_ff <= {1'b0, gain_ff}; idx_ff <= '0; state_ff <= S_SCALE; end
            end
            S_DIVW: if (div_rsp.done) begin
               fac_ff <= 4'(div_rsp.quotient); idx_ff <= '0; state_ff <= S_SCALE;
            end
            S_SCALE: begin
               wheel_ff[16*idx_ff +: 16] <= mp[15:0];
               idx_ff <= idx_ff + 2'd1;
               if (idx_ff == 2'd3) state_ff <= S_OUT;
            end
            // hand over to the rsp register once the previous word is gone
            S_OUT: if (!rsp_valid_ff) begin
               rsp_data_ff <= wheel_ff; rsp_valid_ff <= 1'b1; state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `MYPM_ASSERT_IMP(a_no_accept_busy, clock, reset, state_ff != S_IDLE, !req_tready)
   `MYPM_ASSERT_NXT(a_corr_bound, clock, reset, state_ff == S_CORR, absv(14'(corr_ff)) <= 14'(lim_ff))
   `MYPM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
endmodule

>>> rtl/mypm_divider.sv
// Restoring serial divider, one quotient bit per cycle, unsigned.
// Depends on mypm_pkg.
module mypm_divider
   import mypm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);
   logic [DIV_W-1:0] rem_ff, rem_in, quo_ff, quo_in, den_ff, den_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [DIV_W:0]   trial;

   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff; den_in = den_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial  = {rem_ff, quo_ff[DIV_W-1]};
      if (div_req.start) begin
         rem_in = '0; quo_in = div_req.dividend; den_in = div_req.divisor;
         cnt_in = 5'(DIV_W); busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in next dividend bit, subtract when it fits
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DIV_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in; quo_ff <= quo_in; den_ff <= den_in;
      if (reset) begin
         cnt_ff <= '0; busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in; busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;
endmodule
